### rtl/bc3s3_pkg.sv
// Shared types and constants for the 3x3 stride-3 block convolution unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bc3s3_pkg;

  // Payload widths of the channels.
  localparam int unsigned PixelW    = 16;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned ProdW     = 32;
  localparam int unsigned SumW      = 35;
  localparam int unsigned BlkRowW   = 16;
  localparam int unsigned BlkColW   = 9;
  localparam int unsigned KernRowW  = 48;
  localparam int unsigned ColCountW = 11;
  localparam int unsigned BlkCntW   = 10;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 48;

  // Reciprocal of three, scaled by 2^13, for the block-per-row count.
  localparam int unsigned RecipThree  = 2731;
  localparam int unsigned RecipShift  = 13;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_KERNEL_TOP    = 2'd0,
    REG_KERNEL_MID    = 2'd1,
    REG_KERNEL_BOTTOM = 2'd2,
    REG_COLUMN_COUNT  = 2'd3
  } cfg_reg_e;

endpackage : bc3s3_pkg

`default_nettype wire

### rtl/bc3s3_intf.sv
// Valid/ready channel interfaces: pixel input, block result output and
// configuration writes. Depends on bc3s3_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface bc3s3_pix_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bc3s3_pkg::PixelW-1:0]     pixel;
  logic                                    frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface : bc3s3_pix_if

interface bc3s3_res_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [bc3s3_pkg::SumW-1:0]       block_sum;
  logic        [bc3s3_pkg::BlkRowW-1:0]    block_row;
  logic        [bc3s3_pkg::BlkColW-1:0]    block_col;

  modport source (output valid, output block_sum, output block_row, output block_col,
                  input ready);
  modport sink   (input valid, input block_sum, input block_row, input block_col,
                  output ready);
endinterface : bc3s3_res_if

interface bc3s3_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [bc3s3_pkg::CfgIdxW-1:0]           reg_idx;
  logic [bc3s3_pkg::CfgDataW-1:0]          wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface : bc3s3_cfg_if

`default_nettype wire

### rtl/block_conv3x3_stride3_unit.sv
// Top level of the 3x3 stride-3 block convolution unit.
// Depends on bc3s3_pkg and the channel interfaces in bc3s3_intf.sv.
//
// Usage:
//   pix_i carries one signed pixel per request in row-major order; frame_start
//   marks the first pixel of an image and restarts all position counters.
//   res_o carries one request per complete 3x3 block: the nine-product sum and
//   the block's row and column index. Pixels in trailing columns or rows that
//   do not fill a whole block produce nothing.
//   cfg_i writes the three kernel rows and the row length; it is always ready
//   and must only be used while no pixel is in flight.
// Pipeline and throughput:
//   One pixel is taken every cycle while res_o is not stalled. The result of a
//   block goes from its bottom-right pixel through stage 1 and stage 2 into the
//   output register. The rate is set by the per-block-column accumulator memory,
//   which has one read and one write port and a registered read; back-to-back
//   updates of an entry are forwarded from the adder and write-back register.
// Reset:
//   Clears the kernel to zero, sets the row length to three and clears all
//   counters and valid flags. The accumulator memory is not cleared; every
//   entry is started on a block's first pixel before it is read.
// Stall:
//   While res_o is not taken the whole pipeline holds and pix_i.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module block_conv3x3_stride3_unit #(
  parameter int unsigned MAX_BLOCK_COLS = 512
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  bc3s3_pix_if.sink         pix_i,
  bc3s3_res_if.source       res_o,
  bc3s3_cfg_if.sink         cfg_i
);

  localparam int unsigned AddrW = (MAX_BLOCK_COLS > 1) ? $clog2(MAX_BLOCK_COLS) : 1;
  localparam int unsigned CapW  = 13;
  localparam int unsigned CcW   = bc3s3_pkg::ColCountW;
  localparam int unsigned BcW   = bc3s3_pkg::BlkCntW;
  localparam int unsigned RowW  = bc3s3_pkg::BlkRowW;
  localparam int unsigned SumW  = bc3s3_pkg::SumW;
  localparam int unsigned ProdW = bc3s3_pkg::ProdW;
  localparam int unsigned CoefW = bc3s3_pkg::CoefW;
  localparam int unsigned PixW  = bc3s3_pkg::PixelW;
  localparam int unsigned KrW   = bc3s3_pkg::KernRowW;
  localparam int unsigned MulW  = CcW + 12;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [KrW-1:0]  kern_top_q, kern_mid_q, kern_bot_q;
  logic [CcW-1:0]  col_cnt_q;
  logic [BcW-1:0]  nblk_q;
  logic            cfg_we;
  logic [CcW-1:0]  cfg_cc;
  logic [MulW-1:0] cfg_mul;
  logic [BcW-1:0]  cfg_div3;
  logic [BcW-1:0]  cfg_nblk;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // Row length with zero taken as one, and the number of whole blocks in a row.
  always_comb begin
    cfg_cc = cfg_i.wdata[CcW-1:0];
    if (cfg_cc == '0) begin
      cfg_cc = CcW'(1);
    end
    cfg_mul  = MulW'(cfg_cc) * MulW'(bc3s3_pkg::RecipThree);
    cfg_div3 = cfg_mul[bc3s3_pkg::RecipShift +: BcW];
    if (CapW'(cfg_div3) > CapW'(MAX_BLOCK_COLS)) begin
      cfg_nblk = BcW'(MAX_BLOCK_COLS);
    end else begin
      cfg_nblk = cfg_div3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_top_q <= '0;
      kern_mid_q <= '0;
      kern_bot_q <= '0;
      col_cnt_q  <= CcW'(3);
      nblk_q     <= BcW'(1);
    end else if (cfg_we) begin
      unique case (bc3s3_pkg::cfg_reg_e'(cfg_i.reg_idx))
        bc3s3_pkg::REG_KERNEL_TOP:    kern_top_q <= cfg_i.wdata;
        bc3s3_pkg::REG_KERNEL_MID:    kern_mid_q <= cfg_i.wdata;
        bc3s3_pkg::REG_KERNEL_BOTTOM: kern_bot_q <= cfg_i.wdata;
        bc3s3_pkg::REG_COLUMN_COUNT: begin
          col_cnt_q <= cfg_cc;
          nblk_q    <= cfg_nblk;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: everything advances together when the output frees up
  // ---------------------------------------------------------------------
  logic out_vld_q;
  logic adv;
  logic accept;

  assign adv         = !out_vld_q || res_o.ready;
  assign pix_i.ready = adv;
  assign accept      = pix_i.valid && adv;

  // ---------------------------------------------------------------------
  // Position counters
  // ---------------------------------------------------------------------
  logic [1:0]      cib_q, rib_q;
  logic [BcW-1:0]  bcc_q;
  logic [CcW-1:0]  pcc_q;
  logic [RowW-1:0] brc_q;

  logic [1:0]      cib, rib, cib_d, rib_d;
  logic [BcW-1:0]  bcc, bcc_d;
  logic [CcW-1:0]  pcc, pcc_d;
  logic [RowW-1:0] brc, brc_d;
  logic [CcW:0]    pcc_inc;
  logic [1:0]      cib_inc;
  logic            in_range, px_first, px_last;
  logic [KrW-1:0]  kern_row;
  logic [CoefW-1:0] coef;

  always_comb begin
    // A frame start restarts the position before the pixel is placed.
    if (pix_i.frame_start) begin
      cib = '0;
      rib = '0;
      bcc = '0;
      pcc = '0;
      brc = '0;
    end else begin
      cib = cib_q;
      rib = rib_q;
      bcc = bcc_q;
      pcc = pcc_q;
      brc = brc_q;
    end

    in_range = bcc < nblk_q;
    px_first = (rib == 2'd0) && (cib == 2'd0);
    px_last  = (rib == 2'd2) && (cib == 2'd2);

    // Kernel coefficient at this pixel's place in its block.
    unique case (rib)
      2'd0:    kern_row = kern_top_q;
      2'd1:    kern_row = kern_mid_q;
      2'd2:    kern_row = kern_bot_q;
      default: kern_row = '0;
    endcase
    unique case (cib)
      2'd0:    coef = kern_row[0*CoefW +: CoefW];
      2'd1:    coef = kern_row[1*CoefW +: CoefW];
      2'd2:    coef = kern_row[2*CoefW +: CoefW];
      default: coef = '0;
    endcase

    // Advance within the block, then along the row.
    cib_inc = cib + 2'd1;
    cib_d   = cib_inc;
    bcc_d   = bcc;
    if (cib_inc == 2'd3) begin
      cib_d = '0;
      if (bcc != {BcW{1'b1}}) begin
        bcc_d = bcc + BcW'(1);
      end
    end
    rib_d   = rib;
    brc_d   = brc;
    pcc_inc = {1'b0, pcc} + (CcW+1)'(1);
    pcc_d   = pcc_inc[CcW-1:0];
    if (pcc_inc >= {1'b0, col_cnt_q}) begin
      pcc_d = '0;
      cib_d = '0;
      bcc_d = '0;
      if (rib == 2'd2) begin
        rib_d = '0;
        brc_d = brc + RowW'(1);
      end else begin
        rib_d = rib + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cib_q <= '0;
      rib_q <= '0;
      bcc_q <= '0;
      pcc_q <= '0;
      brc_q <= '0;
    end else if (accept) begin
      cib_q <= cib_d;
      rib_q <= rib_d;
      bcc_q <= bcc_d;
      pcc_q <= pcc_d;
      brc_q <= brc_d;
    end
  end

  // ---------------------------------------------------------------------
  // Accumulator memory, one entry per block column
  // ---------------------------------------------------------------------
  logic [SumW-1:0] acc_mem_q [MAX_BLOCK_COLS];
  logic [SumW-1:0] mem_rd_q;
  logic            mem_we;
  logic [AddrW-1:0] rd_addr, wr_addr;

  // Stage 1: pixel, coefficient and position of the accepted request.
  logic                    s1_vld_q, s1_first_q, s1_last_q;
  logic signed [PixW-1:0]  s1_px_q;
  logic signed [CoefW-1:0] s1_coef_q;
  logic [BcW-1:0]          s1_bcc_q;
  logic [RowW-1:0]         s1_row_q;

  // Stage 2: product and the entry's previous sum.
  logic                    s2_vld_q, s2_first_q, s2_last_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic [SumW-1:0]         s2_old_q;
  logic [BcW-1:0]          s2_bcc_q;
  logic [RowW-1:0]         s2_row_q;

  // Last write, kept for requests whose read raced it.
  logic                    wb_vld_q;
  logic [BcW-1:0]          wb_bcc_q;
  logic [SumW-1:0]         wb_sum_q;

  logic signed [ProdW-1:0] s1_prod;
  logic [SumW-1:0]         s2_prod_ext, s2_sum, s2_old_d;

  assign rd_addr = AddrW'(bcc);
  assign wr_addr = AddrW'(s2_bcc_q);
  assign mem_we  = adv && s2_vld_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      acc_mem_q[wr_addr] <= s2_sum;
    end
    if (adv) begin
      mem_rd_q <= acc_mem_q[rd_addr];
    end
  end

  // Multiply, and pick the freshest copy of the entry being updated.
  always_comb begin
    s1_prod     = s1_px_q * s1_coef_q;
    s2_prod_ext = SumW'(s2_prod_q);
    if (s2_first_q) begin
      s2_sum = s2_prod_ext;
    end else begin
      s2_sum = s2_old_q + s2_prod_ext;
    end
    if (s2_vld_q && (s2_bcc_q == s1_bcc_q)) begin
      s2_old_d = s2_sum;
    end else if (wb_vld_q && (wb_bcc_q == s1_bcc_q)) begin
      s2_old_d = wb_sum_q;
    end else begin
      s2_old_d = mem_rd_q;
    end
  end

  // Valid flags of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= accept && in_range;
      s2_vld_q  <= s1_vld_q;
      wb_vld_q  <= s2_vld_q;
      out_vld_q <= s2_vld_q && s2_last_q;
    end
  end

  // Payload of the pipeline and the output register.
  logic [SumW-1:0] out_sum_q;
  logic [RowW-1:0] out_row_q;
  logic [BcW-1:0]  out_bcc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_px_q    <= pix_i.pixel;
      s1_coef_q  <= coef;
      s1_bcc_q   <= bcc;
      s1_row_q   <= brc;
      s1_first_q <= px_first;
      s1_last_q  <= px_last;

      s2_prod_q  <= s1_prod;
      s2_old_q   <= s2_old_d;
      s2_bcc_q   <= s1_bcc_q;
      s2_row_q   <= s1_row_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;

      wb_bcc_q   <= s2_bcc_q;
      wb_sum_q   <= s2_sum;

      if (s2_vld_q && s2_last_q) begin
        out_sum_q <= s2_sum;
        out_row_q <= s2_row_q;
        out_bcc_q <= s2_bcc_q;
      end
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.block_sum = out_sum_q;
  assign res_o.block_row = out_row_q;
  assign res_o.block_col = bc3s3_pkg::BlkColW'(out_bcc_q);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_block_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cib_q != 2'd3) && (rib_q != 2'd3))
    else $error("position within block left the 3x3 range");

  a_result_from_last_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(s2_vld_q && s2_last_q))
    else $error("result issued without a bottom-right pixel in stage 2");

  a_stall_holds_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(adv) |-> ($stable(s1_vld_q) && $stable(s2_vld_q)))
    else $error("pipeline moved while the output was stalled");

  a_no_write_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (s2_vld_q && (!out_vld_q || res_o.ready)))
    else $error("accumulator written while the pipeline is held");

endmodule : block_conv3x3_stride3_unit

`default_nettype wire
